### rtl/knc_pkg.sv
`timescale 1ns / 1ps

package knc_pkg;

  localparam int MAX_CENTERS = 16;
  localparam int MAX_DIMS    = 8;
  localparam int COORD_BITS  = 16;

  localparam int ID_W        = 16;
  localparam int DIST_W      = 36;
  localparam int MUL_W       = 18;
  localparam int NCAND_REG_W = 5;
  localparam int NDIM_REG_W  = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;

  localparam int SLOT_W       = $clog2(MAX_CENTERS);
  localparam int CAND_CNT_W   = $clog2(MAX_CENTERS + 1);
  localparam int DIM_CNT_W    = $clog2(MAX_DIMS + 1);
  localparam int COORD_ADDR_W = $clog2(MAX_CENTERS * MAX_DIMS);
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int MAG_W        = (DIFF_W > MUL_W) ? DIFF_W : MUL_W + 1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_POINT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CANDIDATES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS       = 1'b1;

  typedef struct packed {
    logic                         action;
    logic [3:0]                   slot;
    logic [ID_W-1:0]              candidate_id;
    logic [2:0]                   dim_index;
    logic signed [COORD_BITS-1:0] coord;
    logic [ID_W-1:0]              point_id;
    logic                         last_coord;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0]   out_point_id;
    logic [ID_W-1:0]   nearest_id;
    logic [DIST_W-1:0] nearest_dist;
  } out_word_t;

  typedef struct packed {
    logic              take_load;
    logic              take_point;
    logic              issue;
    logic [SLOT_W-1:0] idx;
    logic              emit;
  } knc_cmd_t;

  typedef struct packed {
    logic                  busy;
    logic                  last;
    logic                  out_free;
    logic [CAND_CNT_W-1:0] ncand;
  } knc_status_t;

endpackage

### rtl/knc_ram.sv
`timescale 1ns / 1ps

module knc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/knc_ctrl.sv
`timescale 1ns / 1ps

module knc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_action,
  output logic                in_ready,
  input  knc_pkg::knc_status_t status,
  output knc_pkg::knc_cmd_t   cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } knc_state_t;

  knc_state_t                     state_r, state_nxt;
  logic [knc_pkg::SLOT_W-1:0]     cnt_r, cnt_nxt;
  logic                           accept;
  logic                           walk_done;

  always_comb begin
    in_ready       = (state_r == ST_IDLE);
    accept         = in_valid && in_ready;
    cmd.take_load  = accept && (in_action == knc_pkg::ACT_LOAD);
    cmd.take_point = accept && (in_action == knc_pkg::ACT_POINT);
    cmd.issue      = (state_r == ST_WALK);
    cmd.idx        = cnt_r;
    cmd.emit       = (state_r == ST_FINISH) && status.out_free;
    walk_done      = ((knc_pkg::CAND_CNT_W'(cnt_r) + knc_pkg::CAND_CNT_W'(1)) == status.ncand);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.take_point) begin
          state_nxt = ST_WALK;
          cnt_nxt   = '0;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + knc_pkg::SLOT_W'(1);
        end
      end
      ST_DRAIN: begin
        // wait for the last slot to reach the accumulate stage
        if (!status.busy) begin
          state_nxt = status.last ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### rtl/knc_dpath.sv
`timescale 1ns / 1ps

module knc_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  knc_pkg::in_word_t                   in_data,
  input  logic                                cfg_wr_en,
  input  logic [knc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [knc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  knc_pkg::knc_cmd_t                   cmd,
  output knc_pkg::knc_status_t                status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output knc_pkg::out_word_t                  out_data
);

  // configuration
  logic [knc_pkg::NCAND_REG_W-1:0] num_cand_r;
  logic [knc_pkg::NDIM_REG_W-1:0]  num_dims_r;
  logic [knc_pkg::CAND_CNT_W-1:0]  ncand_eff;
  logic [knc_pkg::DIM_CNT_W-1:0]   ndim_eff;

  // point word in flight
  logic signed [knc_pkg::COORD_BITS-1:0] pcoord_r;
  logic [knc_pkg::ID_W-1:0]              pid_r;
  logic [2:0]                            pdim_r;
  logic                                  last_r;
  logic                                  act_r;

  // center storage
  logic [knc_pkg::ID_W-1:0]         ids_r [knc_pkg::MAX_CENTERS];
  logic                             load_ok;
  logic                             ram_we;
  logic [knc_pkg::COORD_ADDR_W-1:0] ram_waddr;
  logic [knc_pkg::COORD_ADDR_W-1:0] ram_raddr;
  logic [knc_pkg::COORD_BITS-1:0]   ram_rdata;

  // pipeline
  logic                              s1_valid_r;
  logic [knc_pkg::SLOT_W-1:0]        s1_idx_r;
  logic                              s2_valid_r;
  logic [knc_pkg::SLOT_W-1:0]        s2_idx_r;
  logic [knc_pkg::MAG_W-1:0]         s2_mag_r;
  logic                              s3_valid_r;
  logic [knc_pkg::SLOT_W-1:0]        s3_idx_r;
  logic [knc_pkg::DIST_W-1:0]        s3_sq_r;

  logic signed [knc_pkg::DIFF_W-1:0] diff;
  logic [knc_pkg::DIFF_W-1:0]        mag;
  logic                              sq_ovf;
  logic [knc_pkg::DIST_W-1:0]        sq;
  logic [knc_pkg::DIST_W:0]          acc_sum;
  logic [knc_pkg::DIST_W-1:0]        acc_new;

  logic [knc_pkg::DIST_W-1:0] partial_r [knc_pkg::MAX_CENTERS];
  logic [knc_pkg::DIST_W-1:0] best_d_r;
  logic [knc_pkg::SLOT_W-1:0] best_idx_r;

  logic               out_valid_r;
  knc_pkg::out_word_t out_data_r;

  always_comb begin
    if (num_cand_r == '0) begin
      ncand_eff = knc_pkg::CAND_CNT_W'(1);
    end else if (32'(num_cand_r) > knc_pkg::MAX_CENTERS) begin
      ncand_eff = knc_pkg::CAND_CNT_W'(knc_pkg::MAX_CENTERS);
    end else begin
      ncand_eff = knc_pkg::CAND_CNT_W'(num_cand_r);
    end
    if (num_dims_r == '0) begin
      ndim_eff = knc_pkg::DIM_CNT_W'(1);
    end else if (32'(num_dims_r) > knc_pkg::MAX_DIMS) begin
      ndim_eff = knc_pkg::DIM_CNT_W'(knc_pkg::MAX_DIMS);
    end else begin
      ndim_eff = knc_pkg::DIM_CNT_W'(num_dims_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cand_r <= knc_pkg::NCAND_REG_W'(1);
      num_dims_r <= knc_pkg::NDIM_REG_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        knc_pkg::CFG_NUM_CANDIDATES: num_cand_r <= cfg_wdata[knc_pkg::NCAND_REG_W-1:0];
        knc_pkg::CFG_NUM_DIMS:       num_dims_r <= cfg_wdata[knc_pkg::NDIM_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // loads outside the slot or coordinate range are dropped
  assign load_ok = (32'(in_data.slot) < knc_pkg::MAX_CENTERS) &&
                   (32'(in_data.dim_index) < knc_pkg::MAX_DIMS);
  assign ram_we  = cmd.take_load && load_ok;
  assign ram_waddr = knc_pkg::COORD_ADDR_W'(in_data.slot) *
                     knc_pkg::COORD_ADDR_W'(knc_pkg::MAX_DIMS) +
                     knc_pkg::COORD_ADDR_W'(in_data.dim_index);
  assign ram_raddr = knc_pkg::COORD_ADDR_W'(cmd.idx) *
                     knc_pkg::COORD_ADDR_W'(knc_pkg::MAX_DIMS) +
                     knc_pkg::COORD_ADDR_W'(pdim_r);

  knc_ram #(
    .WIDTH (knc_pkg::COORD_BITS),
    .DEPTH (knc_pkg::MAX_CENTERS * knc_pkg::MAX_DIMS)
  ) u_coord_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_data.coord),
    .rd_en   (cmd.issue),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ids_r[knc_pkg::SLOT_W'(in_data.slot)] <= in_data.candidate_id;
    end
    if (cmd.take_point) begin
      pcoord_r <= in_data.coord;
      pid_r    <= in_data.point_id;
      pdim_r   <= in_data.dim_index;
      act_r    <= (32'(in_data.dim_index) < 32'(ndim_eff));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 1'b0;
    end else if (cmd.take_point) begin
      last_r <= in_data.last_coord;
    end
  end

  always_comb begin
    diff    = knc_pkg::DIFF_W'(pcoord_r) - knc_pkg::DIFF_W'($signed(ram_rdata));
    mag     = diff[knc_pkg::DIFF_W-1] ? $unsigned(-diff) : $unsigned(diff);
    sq_ovf  = (s2_mag_r >> knc_pkg::MUL_W) != '0;
    sq      = knc_pkg::DIST_W'(s2_mag_r[knc_pkg::MUL_W-1:0]) *
              knc_pkg::DIST_W'(s2_mag_r[knc_pkg::MUL_W-1:0]);
    acc_sum = {1'b0, partial_r[s3_idx_r]} + {1'b0, s3_sq_r};
    acc_new = acc_sum[knc_pkg::DIST_W] ? knc_pkg::DIST_MAX : acc_sum[knc_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.issue;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= cmd.idx;
    s2_idx_r <= s1_idx_r;
    s2_mag_r <= knc_pkg::MAG_W'(mag);
    s3_idx_r <= s2_idx_r;
    // a coordinate past the point's size adds nothing
    if (!act_r) begin
      s3_sq_r <= '0;
    end else if (sq_ovf) begin
      s3_sq_r <= knc_pkg::DIST_MAX;
    end else begin
      s3_sq_r <= sq;
    end
    // slot 0 seeds the search; strict less-than keeps the lowest slot on ties
    if (s3_valid_r && ((s3_idx_r == '0) || (acc_new < best_d_r))) begin
      best_d_r   <= acc_new;
      best_idx_r <= s3_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      for (int i = 0; i < knc_pkg::MAX_CENTERS; i++) begin
        partial_r[i] <= '0;
      end
    end else if (s3_valid_r) begin
      partial_r[s3_idx_r] <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.out_point_id <= pid_r;
      out_data_r.nearest_id   <= ids_r[best_idx_r];
      out_data_r.nearest_dist <= best_d_r;
    end
  end

  always_comb begin
    status.busy     = s1_valid_r || s2_valid_r;
    status.last     = last_r;
    status.out_free = !out_valid_r || out_ready;
    status.ncand    = ncand_eff;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/kmeans_nearest_center.sv
`timescale 1ns / 1ps

// channel | direction | handshake            | word
// in      | input     | in_valid / in_ready   | knc_pkg::in_word_t
// out     | output    | out_valid / out_ready | knc_pkg::out_word_t
// cfg     | input     | cfg_wr_en             | cfg_index, cfg_wdata
//
// A load word is written to the center storage when taken. A point word walks the N
// active candidates (N the active candidate count), one coordinate memory read per
// slot, then waits for the read, square and accumulate stages to empty. A last
// coordinate then moves the result into the output register once it is free.
// Reset is synchronous and needs no clearing pass; running distances clear at once.
// A stalled output holds its word. Loads and non-final coordinates still pass, but
// the next result waits for it and holds off all input while it waits.

module kmeans_nearest_center (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  knc_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output knc_pkg::out_word_t             out_data,
  input  logic                           cfg_wr_en,
  input  logic [knc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [knc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  knc_pkg::knc_cmd_t    cmd;
  knc_pkg::knc_status_t status;

  knc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  knc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_walk_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !in_ready)
    else $error("input accepted during candidate walk");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result emitted over an untaken word");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("output word appeared without emit");
`endif

endmodule
